// ----- src/open_address_hash_table_defines.svh -----
// Assertion macros for the open address hash table checks.
`ifndef OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define OAHT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/oaht_pkg.sv -----
// Shared constants, codes and control types of the open address hash table.
package oaht_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int SLOT_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = SLOT_W + 1;
  localparam int OP_W         = 2;
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int SLOT_INDEX_W = 6;
  localparam int ENTRY_W      = KEY_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic start;
    logic probe;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } stat_t;

endpackage

// ----- src/oaht_in_if.sv -----
// Request channel of the open address hash table.
interface oaht_in_if;
  import oaht_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [KEY_W-1:0] lookup_key;
  logic signed [VAL_W-1:0] entry_value;

  modport source (output valid, opcode, lookup_key, entry_value, input ready);
  modport sink   (input valid, opcode, lookup_key, entry_value, output ready);
endinterface

// ----- src/oaht_out_if.sv -----
// Result channel of the open address hash table.
interface oaht_out_if;
  import oaht_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] found_value;
  logic [SLOT_INDEX_W-1:0] slot_index;

  modport source (output valid, status, found_value, slot_index, input ready);
  modport sink   (input valid, status, found_value, slot_index, output ready);
endinterface

// ----- src/oaht_ram.sv -----
// Generic simple dual port RAM with registered read.
module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/oaht_ctrl.sv -----
// Controller state machine: accept, probe, commit and hand off the result.
module oaht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output oaht_pkg::cmd_t cmd,
  input  oaht_pkg::stat_t stat
);
  import oaht_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (stat.done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
      end
      S_RESP: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- src/oaht_dpath.sv -----
// Datapath: probe sequence, slot storage, decision logic and result register.
module oaht_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  oaht_pkg::cmd_t                    cmd,
  output oaht_pkg::stat_t                   stat,
  input  logic [oaht_pkg::OP_W-1:0]         in_opcode,
  input  logic signed [oaht_pkg::KEY_W-1:0] in_key,
  input  logic signed [oaht_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [oaht_pkg::STATUS_W-1:0]     out_status,
  output logic signed [oaht_pkg::VAL_W-1:0] out_value,
  output logic [oaht_pkg::SLOT_INDEX_W-1:0] out_slot
);
  import oaht_pkg::*;

  logic [OP_W-1:0]        op_r;
  logic [KEY_W-1:0]       key_r;
  logic [VAL_W-1:0]       val_r;
  logic [SLOT_W-1:0]      home_r;
  logic [SLOT_W-1:0]      tri_r;
  logic [CNT_W-1:0]       iss_cnt_r;
  logic                   rd_vld_r;
  logic                   rd_last_r;
  logic [SLOT_W-1:0]      rd_pos_r;
  logic                   have_tomb_r;
  logic [SLOT_W-1:0]      tomb_r;
  logic [TABLE_DEPTH-1:0] occ_r;

  status_t                res_status_r;
  logic [VAL_W-1:0]       res_value_r;
  logic [SLOT_W-1:0]      res_slot_r;
  logic                   res_write_r;
  logic                   res_del_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [VAL_W-1:0]       out_value_r;
  logic [SLOT_W-1:0]      out_slot_r;

  logic [SLOT_W-1:0]      home_nxt;
  logic [SLOT_W-1:0]      probe_pos;
  logic                   issue;
  logic [ENTRY_W-1:0]     ent_rdata;
  logic [VAL_W-1:0]       val_rdata;
  logic                   slot_occ;
  logic                   is_empty;
  logic                   is_del;
  logic                   key_hit;
  logic                   stop;
  logic                   done;
  status_t                dec_status;
  logic [VAL_W-1:0]       dec_value;
  logic [SLOT_W-1:0]      dec_slot;
  logic                   dec_write;
  logic                   dec_del;
  logic [SLOT_W-1:0]      tomb_pick;
  logic                   ent_we;
  logic                   val_we;

  // Home slot: low bits of the key magnitude.
  assign home_nxt  = in_key[KEY_W-1] ? SLOT_W'(~in_key[SLOT_W-1:0] + 1'b1)
                                     : in_key[SLOT_W-1:0];
  assign probe_pos = home_r + tri_r;
  assign issue     = cmd.probe && (iss_cnt_r != CNT_W'(TABLE_DEPTH));

  assign slot_occ  = occ_r[rd_pos_r];
  assign is_empty  = !slot_occ;
  assign is_del    = slot_occ && ent_rdata[KEY_W];
  assign key_hit   = slot_occ && !ent_rdata[KEY_W] && (ent_rdata[KEY_W-1:0] == key_r);
  assign tomb_pick = have_tomb_r ? tomb_r : rd_pos_r;

  always_comb begin
    stop       = 1'b0;
    dec_status = ST_MISS;
    dec_value  = '0;
    dec_slot   = '0;
    dec_write  = 1'b0;
    dec_del    = 1'b0;
    unique case (op_r)
      OP_INSERT: begin
        if (key_hit) begin
          stop       = 1'b1;
          dec_status = ST_DUP;
        end else if (is_empty) begin
          stop       = 1'b1;
          dec_status = ST_OK;
          dec_slot   = tomb_pick;
          dec_write  = 1'b1;
        end else if (rd_last_r) begin
          stop = 1'b1;
          if (have_tomb_r || is_del) begin
            dec_status = ST_OK;
            dec_slot   = tomb_pick;
            dec_write  = 1'b1;
          end else begin
            dec_status = ST_FULL;
          end
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        if (key_hit) begin
          stop       = 1'b1;
          dec_status = ST_OK;
          dec_slot   = rd_pos_r;
          if (op_r == OP_SEARCH) begin
            dec_value = val_rdata;
          end else begin
            dec_write = 1'b1;
            dec_del   = 1'b1;
          end
        end else if (is_empty || rd_last_r) begin
          stop = 1'b1;
        end
      end
      default: begin
        stop = 1'b1;
      end
    endcase
  end

  assign done          = rd_vld_r && stop;
  assign stat.done     = done;
  assign stat.out_free = !out_valid_r || out_ready;

  assign ent_we = cmd.commit && res_write_r;
  assign val_we = ent_we && !res_del_r;

  oaht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (res_slot_r),
    .wdata ({res_del_r, key_r}),
    .raddr (probe_pos),
    .rdata (ent_rdata)
  );

  oaht_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (res_slot_r),
    .wdata (val_r),
    .raddr (probe_pos),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      have_tomb_r <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.start) begin
        iss_cnt_r   <= '0;
        have_tomb_r <= 1'b0;
      end else begin
        if (issue) begin
          iss_cnt_r <= iss_cnt_r + 1'b1;
        end
        if (cmd.probe && rd_vld_r && is_del && !have_tomb_r) begin
          have_tomb_r <= 1'b1;
        end
      end
      if (ent_we && !res_del_r) begin
        occ_r[res_slot_r] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= in_opcode;
      key_r  <= in_key;
      val_r  <= in_value;
      home_r <= home_nxt;
      tri_r  <= '0;
    end else if (issue) begin
      tri_r <= tri_r + SLOT_W'(iss_cnt_r + 1'b1);
    end
    if (issue) begin
      rd_pos_r  <= probe_pos;
      rd_last_r <= (iss_cnt_r == CNT_W'(TABLE_DEPTH - 1));
    end
    if (cmd.probe && rd_vld_r && is_del && !have_tomb_r) begin
      tomb_r <= rd_pos_r;
    end
    if (cmd.probe && done) begin
      res_status_r <= dec_status;
      res_value_r  <= dec_value;
      res_slot_r   <= dec_slot;
      res_write_r  <= dec_write;
      res_del_r    <= dec_del;
    end
    if (cmd.commit) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_slot   = SLOT_INDEX_W'(out_slot_r);

endmodule

// ----- src/open_address_hash_table.sv -----
// Top level of the open address hash table.
//
// Key/value table of 64 slots with triangular probing and tombstones.
// in_chan carries one request per transaction: opcode (insert, search,
// remove), a signed key and, for insert, a value. out_chan returns one
// result per request: status, found value and slot index.
// Requests are handled one at a time. A request reads one slot per cycle
// from the slot RAMs; the next request is accepted in the cycle the result
// of the last one appears on out_chan.
// The result sits in an output register; the block takes the next request
// while that register still waits for the receiver. When the receiver
// stalls, a finished request holds in its response state until the output
// register frees up, and no further request is accepted meanwhile.
// Reset (rst_n, synchronous, active low) marks every slot empty at once and
// drops any request in flight; key and value storage is not cleared.
module open_address_hash_table (
  input logic        clk,
  input logic        rst_n,
  oaht_in_if.sink    in_chan,
  oaht_out_if.source out_chan
);
  import oaht_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ctrl_ready;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ctrl_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  oaht_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (in_chan.opcode),
    .in_key     (in_chan.lookup_key),
    .in_value   (in_chan.entry_value),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_status (out_chan.status),
    .out_value  (out_chan.found_value),
    .out_slot   (out_chan.slot_index)
  );

  assign in_chan.ready = ctrl_ready;

endmodule

// ----- src/oaht_checker.sv -----
// Port level checks of the open address hash table, bound to the top level.
`include "open_address_hash_table_defines.svh"

module oaht_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [oaht_pkg::STATUS_W-1:0]     out_status,
  input logic [oaht_pkg::VAL_W-1:0]        out_found_value,
  input logic [oaht_pkg::SLOT_INDEX_W-1:0] out_slot_index
);
  import oaht_pkg::*;

  `OAHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `OAHT_ASSERT_SAME(a_fail_zero, out_valid && (out_status != ST_OK), (out_slot_index == '0) && (out_found_value == '0), "failed result carries nonzero fields")
  `OAHT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")
  `OAHT_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result without a request in flight")

endmodule

bind open_address_hash_table oaht_checker u_oaht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_found_value (out_chan.found_value),
  .out_slot_index  (out_chan.slot_index)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the open address hash table: driver, monitor and table predictor.
`timescale 1ns / 100ps

module testbench;
  import oaht_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AT     = 600;
  localparam int POOL_SIZE   = 96;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_USED    = 2'd1,
    TAG_DELETED = 2'd2
  } tag_t;

  typedef struct {
    opcode_t                 op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] val;
  } request_t;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] value;
    logic [SLOT_INDEX_W-1:0] slot;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  oaht_in_if  in_if ();
  oaht_out_if out_if ();

  open_address_hash_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #4 clk = ~clk;

  tag_t                    slot_tag [TABLE_DEPTH];
  logic signed [KEY_W-1:0] slot_key [TABLE_DEPTH];
  logic signed [VAL_W-1:0] slot_val [TABLE_DEPTH];

  request_t                pending_reqs [$];
  table_result_t           expected_results [$];
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  request_t next_req;
  int       error_count = 0;
  int       results_seen = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit       steady = 1'b0;
  bit       timed_out = 1'b0;
  int       quiet_cycles = 0;

  function automatic table_result_t predict(opcode_t op, logic signed [KEY_W-1:0] key,
                                            logic signed [VAL_W-1:0] val);
    table_result_t   r;
    logic [KEY_W-1:0] mag;
    logic [SLOT_W-1:0] home, pos, tri_off, tomb, target;
    bit have_tomb, have_empty, hit, stop;
    int j;
    r.status = ST_MISS;
    r.value = '0;
    r.slot = '0;
    mag = key[KEY_W-1] ? (32'd0 - key) : key;
    home = SLOT_W'(mag % TABLE_DEPTH);
    tri_off = '0;
    tomb = '0;
    target = '0;
    have_tomb = 1'b0;
    have_empty = 1'b0;
    hit = 1'b0;
    stop = 1'b0;
    for (j = 0; j < TABLE_DEPTH && !stop; j++) begin
      pos = home + tri_off;
      if (slot_tag[pos] == TAG_EMPTY) begin
        have_empty = 1'b1;
        target = pos;
        stop = 1'b1;
      end else if (slot_tag[pos] == TAG_USED && slot_key[pos] == key) begin
        hit = 1'b1;
        target = pos;
        stop = 1'b1;
      end else begin
        if (slot_tag[pos] == TAG_DELETED && !have_tomb) begin
          have_tomb = 1'b1;
          tomb = pos;
        end
        tri_off = tri_off + SLOT_W'(j + 1);
      end
    end
    case (op)
      OP_INSERT: begin
        if (hit) begin
          r.status = ST_DUP;
        end else if (have_tomb || have_empty) begin
          if (have_tomb) target = tomb;
          slot_tag[target] = TAG_USED;
          slot_key[target] = key;
          slot_val[target] = val;
          r.status = ST_OK;
          r.slot = target;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_SEARCH: begin
        if (hit) begin
          r.status = ST_OK;
          r.value = slot_val[target];
          r.slot = target;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          slot_tag[target] = TAG_DELETED;
          r.status = ST_OK;
          r.slot = target;
        end
      end
      default: r.status = ST_MISS;
    endcase
    return r;
  endfunction

  task automatic push_req(opcode_t op, logic signed [KEY_W-1:0] key,
                          logic signed [VAL_W-1:0] val);
    request_t q;
    q.op = op;
    q.key = key;
    q.val = val;
    pending_reqs.push_back(q);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    error_count++;
  endtask

  task automatic wait_idle();
    while (!timed_out && (pending_reqs.size() != 0 || in_if.valid ||
                          expected_results.size() != 0))
      @(negedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    int r, tries, s;
    r = $urandom_range(0, 99);
    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r >= 70 && r < 85) begin
      for (tries = 0; tries < 8; tries++) begin
        s = $urandom_range(0, TABLE_DEPTH - 1);
        if (slot_tag[s] == TAG_USED) begin
          k = slot_key[s];
          break;
        end
      end
    end else if (r >= 85) begin
      k = $urandom;
      if (k == 32'sh8000_0000) k = '0;
    end
    return k;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7FFF_FFFF;
        2: v = '0;
        default: v = -1;
      endcase
    end
    return v;
  endfunction

  task automatic run_round(int count, int insert_w, int search_w, int nhomes);
    logic [SLOT_W-1:0]       homes [8];
    logic signed [KEY_W-1:0] mag;
    int i, r;
    opcode_t op;
    for (i = 0; i < 8; i++) homes[i] = SLOT_W'($urandom);
    for (i = 0; i < POOL_SIZE; i++) begin
      mag = $signed({1'b0, 25'($urandom), homes[$urandom_range(0, nhomes - 1)]});
      key_pool[i] = $urandom_range(0, 1) ? -mag : mag;
    end
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_w) op = OP_INSERT;
      else if (r < insert_w + search_w) op = OP_SEARCH;
      else op = OP_REMOVE;
      push_req(op, pick_key(), pick_value());
    end
    wait_idle();
  endtask

  // driver: hold the payload while stalled, predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid)
        expected_results.push_back(predict(opcode_t'(in_if.opcode), in_if.lookup_key,
                                           in_if.entry_value));
      if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
        next_req = pending_reqs.pop_front();
        in_if.valid <= 1'b1;
        in_if.opcode <= next_req.op;
        in_if.lookup_key <= next_req.key;
        in_if.entry_value <= next_req.val;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: check each result transaction, then pick the next ready
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected result, status", 32'(out_if.status), 32'hFFFF_FFFF);
      end else begin
        want = expected_results.pop_front();
        if (status_t'(out_if.status) != want.status)
          report("status", 32'(out_if.status), 32'(want.status));
        if (out_if.found_value != want.value)
          report("found_value", out_if.found_value, want.value);
        if (out_if.slot_index != want.slot)
          report("slot_index", 32'(out_if.slot_index), 32'(want.slot));
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || $urandom_range(0, 99) >= 33;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin
    int i;
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.lookup_key = '0;
    in_if.entry_value = '0;
    out_if.ready = 1'b0;
    for (i = 0; i < TABLE_DEPTH; i++) slot_tag[i] = TAG_EMPTY;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_req(OP_SEARCH, 5, 0);
    push_req(OP_REMOVE, 5, 0);
    push_req(OP_INSERT, 5, 32'sh7FFF_FFFF);
    push_req(OP_INSERT, 5, 1);
    push_req(OP_SEARCH, 5, 0);
    push_req(OP_INSERT, 69, 32'sh8000_0000);
    push_req(OP_INSERT, -5, -1);
    push_req(OP_INSERT, 2147483647, 0);
    push_req(OP_INSERT, -2147483647, 32'sh5A5A_A5A5);
    push_req(OP_INSERT, 0, -1);
    push_req(OP_SEARCH, 0, 0);
    push_req(OP_REMOVE, 69, 0);
    push_req(OP_SEARCH, -5, 0);
    push_req(OP_SEARCH, 69, 0);
    push_req(OP_REMOVE, 69, 0);
    push_req(OP_INSERT, 133, 32'sh1234_5678);
    push_req(OP_SEARCH, 133, 0);
    push_req(OP_REMOVE, 2147483647, 0);
    push_req(OP_SEARCH, -2147483647, 0);
    push_req(OP_SEARCH, 2147483647, 0);
    push_req(OP_SEARCH, 69, -1);
    push_req(OP_INSERT, 69, 32'sh7FFF_FFFF);
    push_req(OP_SEARCH, 69, 0);
    wait_idle();

    // fill one probe chain until the table is full, then hollow it out
    for (i = 0; i < 70; i++) push_req(OP_INSERT, 3 + 64 * i, i);
    push_req(OP_INSERT, 3, 7);
    push_req(OP_SEARCH, 99999, 0);
    push_req(OP_REMOVE, 3 + 64 * 10, 0);
    push_req(OP_INSERT, 3 + 64 * 80, -1);
    push_req(OP_SEARCH, 3 + 64 * 80, 0);
    push_req(OP_INSERT, -(3 + 64 * 81), 1);
    for (i = 0; i < 82; i++) push_req(OP_REMOVE, 3 + 64 * i, 0);
    push_req(OP_SEARCH, 3 + 64 * 5, 0);
    push_req(OP_INSERT, 3 + 64 * 5, 55);
    push_req(OP_SEARCH, 3 + 64 * 5, 0);
    wait_idle();

    run_round(345, 70, 20, 2);
    run_round(345, 45, 30, 4);
    run_round(345, 20, 30, 3);
    steady = 1'b1;
    run_round(345, 45, 30, 8);
    steady = 1'b0;
    run_round(345, 40, 35, 8);

    if (!timed_out) repeat (80) @(posedge clk);
    if (expected_results.size() != 0)
      report("results never returned", 32'(expected_results.size()), 32'd0);
    if (!timed_out && error_count == 0)
      $display("[open_address_hash_table] OK");
    else
      $display("[open_address_hash_table] ERROR");
    $finish;
  end

endmodule
